>>> sv/assert_macros.svh
// assertion macros used by the top-level rtl file of the epoch to civil converter
// no dependencies; define ASSERT_OFF to compile the checks away
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// implication whose consequent is checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, prop)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> sv/ecv_pkg.sv
// types, constants and tables of the epoch to civil converter
// no dependencies; used by every module of the block
`default_nettype none

package ecv_pkg;

  localparam int SECS_W = 41;

  // seconds per day is 128 * 675: low seven bits split off, then divide by 675
  localparam int DAY_DIV      = 675;
  localparam int DAYS_SHIFT   = 719468;
  localparam int DAYS_PER_ERA = 146097;

  // bias that makes every input non-negative and leaves era boundaries in place
  localparam int ERA_BIAS = 83;
  localparam int DAY_BIAS = DAYS_SHIFT + ERA_BIAS * DAYS_PER_ERA;
  localparam logic [41:0] SEC_BIAS = 42'(64'(DAY_BIAS) * 64'd86400);

  // reciprocals m = ceil(2^(n+l) / d), exact for operands below 2^n
  localparam logic [18:0] M675_H  = 19'(((64'd1 << 28) + 64'd674) / 64'd675);
  localparam logic [27:0] M675_L  = 28'(((64'd1 << 37) + 64'd674) / 64'd675);
  localparam logic [25:0] M_ERA   = 26'(((64'd1 << 43) + 64'd146096) / 64'd146097);
  localparam logic [17:0] M_3600  = 18'(((64'd1 << 29) + 64'd3599) / 64'd3600);
  localparam logic [12:0] M_60    = 13'(((64'd1 << 18) + 64'd59) / 64'd60);
  localparam logic [18:0] M_1460  = 19'(((64'd1 << 29) + 64'd1459) / 64'd1460);
  localparam logic [18:0] M_36524 = 19'(((64'd1 << 34) + 64'd36523) / 64'd36524);
  localparam logic [18:0] M_365   = 19'(((64'd1 << 27) + 64'd364) / 64'd365);

  localparam logic [17:0] DOE_LAST = 18'(DAYS_PER_ERA - 1);

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } ecv_tod_t;

  typedef struct packed {
    logic [24:0] q;
    logic [16:0] sod;
    logic        oor;
  } ecv_days_t;

  typedef struct packed {
    logic [17:0]        t;
    logic [17:0]        doe;
    logic signed [16:0] era400;
    ecv_tod_t           tod;
    logic               oor;
  } ecv_era_t;

  typedef struct packed {
    logic signed [16:0] year;
    logic [3:0]         month;
    logic [4:0]         day;
    ecv_tod_t           tod;
    logic               oor;
  } ecv_result_t;

  // first day of each month in a march-based year
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    case (mp)
      4'd0:    return 9'd0;
      4'd1:    return 9'd31;
      4'd2:    return 9'd61;
      4'd3:    return 9'd92;
      4'd4:    return 9'd122;
      4'd5:    return 9'd153;
      4'd6:    return 9'd184;
      4'd7:    return 9'd214;
      4'd8:    return 9'd245;
      4'd9:    return 9'd275;
      4'd10:   return 9'd306;
      4'd11:   return 9'd337;
      default: return 9'd0;
    endcase
  endfunction

endpackage

`default_nettype wire

>>> sv/ecv_split.sv
// seconds to biased day number and second of day, five register stages
// depends on ecv_pkg
`default_nettype none

module ecv_split
  import ecv_pkg::*;
#(
  parameter int SECONDS_BITS = 41
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     up_valid,
  output logic                     up_ready,
  input  logic signed [SECS_W-1:0] up_secs,
  output logic                     dn_valid,
  input  logic                     dn_ready,
  output ecv_days_t                dn_data
);

  localparam int DEPTH   = 5;
  localparam int CHK_LSB = (SECONDS_BITS < SECS_W) ? SECONDS_BITS - 1 : SECS_W - 1;

  logic [DEPTH-1:0] vld_r, vld_nxt, adv;

  always_comb begin
    adv[DEPTH-1] = !vld_r[DEPTH-1] || dn_ready;
    for (int k = DEPTH - 2; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    if (adv[0]) begin
      vld_nxt[0] = up_valid;
    end
    for (int k = 1; k < DEPTH; k++) begin
      if (adv[k]) begin
        vld_nxt[k] = vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign up_ready = adv[0];
  assign dn_valid = vld_r[DEPTH-1];

  // stage 1: bias and range check
  logic [41:0] u1_r, u1_nxt;
  logic        oor1_r, oor_nxt;
  logic [SECS_W-1:CHK_LSB] top_bits;

  assign top_bits = up_secs[SECS_W-1:CHK_LSB];
  assign oor_nxt  = !((&top_bits) || !(|top_bits));
  assign u1_nxt   = {up_secs[SECS_W-1], up_secs} + SEC_BIAS;

  // stage 2: upper half divided by 675
  logic [36:0] ph;
  logic [8:0]  qh2_r, qh_nxt;
  logic [17:0] xh2_r;
  logic [16:0] xl2_r;
  logic [6:0]  lo2_r;
  logic        oor2_r;

  assign ph     = 37'(u1_r[41:24]) * 37'(M675_H);
  assign qh_nxt = ph[36:28];

  // stage 3: remainder of the upper half joined with the lower half
  logic [17:0] rh_full;
  logic [26:0] y3_r, y_nxt;
  logic [8:0]  qh3_r;
  logic [6:0]  lo3_r;
  logic        oor3_r;

  assign rh_full = xh2_r - 18'(qh2_r) * 18'(DAY_DIV);
  assign y_nxt   = {rh_full[9:0], xl2_r};

  // stage 4: lower part divided by 675
  logic [54:0] pl;
  logic [16:0] ql4_r, ql_nxt;
  logic [26:0] y4_r;
  logic [8:0]  qh4_r;
  logic [6:0]  lo4_r;
  logic        oor4_r;

  assign pl     = 55'(y3_r) * 55'(M675_L);
  assign ql_nxt = pl[53:37];

  // stage 5: day number and second of day
  logic [26:0] rl_full;
  logic [24:0] q5_r, q_nxt;
  logic [16:0] sod5_r, sod_nxt;
  logic        oor5_r;

  assign rl_full = y4_r - 27'(ql4_r) * 27'(DAY_DIV);
  assign q_nxt   = 25'({qh4_r, ql4_r});
  assign sod_nxt = {rl_full[9:0], lo4_r};

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      u1_r   <= u1_nxt;
      oor1_r <= oor_nxt;
    end
    if (adv[1]) begin
      qh2_r  <= qh_nxt;
      xh2_r  <= u1_r[41:24];
      xl2_r  <= u1_r[23:7];
      lo2_r  <= u1_r[6:0];
      oor2_r <= oor1_r;
    end
    if (adv[2]) begin
      y3_r   <= y_nxt;
      qh3_r  <= qh2_r;
      lo3_r  <= lo2_r;
      oor3_r <= oor2_r;
    end
    if (adv[3]) begin
      ql4_r  <= ql_nxt;
      y4_r   <= y3_r;
      qh4_r  <= qh3_r;
      lo4_r  <= lo3_r;
      oor4_r <= oor3_r;
    end
    if (adv[4]) begin
      q5_r   <= q_nxt;
      sod5_r <= sod_nxt;
      oor5_r <= oor4_r;
    end
  end

  assign dn_data.q   = q5_r;
  assign dn_data.sod = sod5_r;
  assign dn_data.oor = oor5_r;

endmodule

`default_nettype wire

>>> sv/ecv_era.sv
// era and day of era, year-of-era numerator, hour, minute and second
// depends on ecv_pkg; four register stages
`default_nettype none

module ecv_era
  import ecv_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      up_valid,
  output logic      up_ready,
  input  ecv_days_t up_data,
  output logic      dn_valid,
  input  logic      dn_ready,
  output ecv_era_t  dn_data
);

  localparam int DEPTH = 4;

  logic [DEPTH-1:0] vld_r, vld_nxt, adv;

  always_comb begin
    adv[DEPTH-1] = !vld_r[DEPTH-1] || dn_ready;
    for (int k = DEPTH - 2; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    if (adv[0]) begin
      vld_nxt[0] = up_valid;
    end
    for (int k = 1; k < DEPTH; k++) begin
      if (adv[k]) begin
        vld_nxt[k] = vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign up_ready = adv[0];
  assign dn_valid = vld_r[DEPTH-1];

  // stage 1: biased era and hour
  logic [50:0] pe;
  logic [34:0] phr;
  logic [7:0]  eq1_r, eq_nxt;
  logic [4:0]  hr1_r, hr_nxt;
  logic [24:0] q1_r;
  logic [16:0] sod1_r;
  logic        oor1_r;

  assign pe     = 51'(up_data.q) * 51'(M_ERA);
  assign eq_nxt = pe[50:43];
  assign phr    = 35'(up_data.sod) * 35'(M_3600);
  assign hr_nxt = phr[33:29];

  // stage 2: day of era, seconds within the hour, era times 400
  logic [24:0]        doe_full;
  logic [16:0]        remh_full;
  logic signed [8:0]  era;
  logic signed [16:0] era_ext;
  logic [17:0]        doe2_r;
  logic [11:0]        remh2_r;
  logic signed [16:0] e400_2_r, e400_nxt;
  logic [4:0]         hr2_r;
  logic               oor2_r;

  assign doe_full  = q1_r - 25'(eq1_r) * 25'(DAYS_PER_ERA);
  assign remh_full = sod1_r - 17'(hr1_r) * 17'd3600;
  assign era       = $signed({1'b0, eq1_r}) - 9'(ERA_BIAS);
  assign era_ext   = 17'(era);
  assign e400_nxt  = era_ext * 17'sd400;

  // stage 3: leap corrections and minute
  logic [36:0] pa, pb;
  logic [24:0] pm;
  logic [6:0]  a3_r;
  logic [1:0]  b3_r;
  logic        c3_r;
  logic [5:0]  mi3_r;
  logic [17:0] doe3_r;
  logic [11:0] remh3_r;
  logic signed [16:0] e400_3_r;
  logic [4:0]  hr3_r;
  logic        oor3_r;

  assign pa = 37'(doe2_r) * 37'(M_1460);
  assign pb = 37'(doe2_r) * 37'(M_36524);
  assign pm = 25'(remh2_r) * 25'(M_60);

  // stage 4: year-of-era numerator and second
  logic [17:0] t_nxt;
  logic [11:0] sec_full;
  logic [17:0] t4_r, doe4_r;
  logic signed [16:0] e400_4_r;
  ecv_tod_t    tod4_r;
  logic        oor4_r;

  assign t_nxt    = doe3_r - 18'(a3_r) + 18'(b3_r) - 18'(c3_r);
  assign sec_full = remh3_r - 12'(mi3_r) * 12'd60;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      eq1_r  <= eq_nxt;
      hr1_r  <= hr_nxt;
      q1_r   <= up_data.q;
      sod1_r <= up_data.sod;
      oor1_r <= up_data.oor;
    end
    if (adv[1]) begin
      doe2_r   <= doe_full[17:0];
      remh2_r  <= remh_full[11:0];
      e400_2_r <= e400_nxt;
      hr2_r    <= hr1_r;
      oor2_r   <= oor1_r;
    end
    if (adv[2]) begin
      a3_r     <= pa[35:29];
      b3_r     <= pb[35:34];
      c3_r     <= (doe2_r == DOE_LAST);
      mi3_r    <= pm[23:18];
      doe3_r   <= doe2_r;
      remh3_r  <= remh2_r;
      e400_3_r <= e400_2_r;
      hr3_r    <= hr2_r;
      oor3_r   <= oor2_r;
    end
    if (adv[3]) begin
      t4_r          <= t_nxt;
      doe4_r        <= doe3_r;
      e400_4_r      <= e400_3_r;
      tod4_r.hour   <= hr3_r;
      tod4_r.minute <= mi3_r;
      tod4_r.second <= sec_full[5:0];
      oor4_r        <= oor3_r;
    end
  end

  assign dn_data.t      = t4_r;
  assign dn_data.doe    = doe4_r;
  assign dn_data.era400 = e400_4_r;
  assign dn_data.tod    = tod4_r;
  assign dn_data.oor    = oor4_r;

endmodule

`default_nettype wire

>>> sv/ecv_date.sv
// year of era, day of year, month, day and year; last stage is the output register
// depends on ecv_pkg; five register stages
`default_nettype none

module ecv_date
  import ecv_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        up_valid,
  output logic        up_ready,
  input  ecv_era_t    up_data,
  output logic        dn_valid,
  input  logic        dn_ready,
  output ecv_result_t dn_data
);

  localparam int DEPTH = 5;

  logic [DEPTH-1:0] vld_r, vld_nxt, adv;

  always_comb begin
    adv[DEPTH-1] = !vld_r[DEPTH-1] || dn_ready;
    for (int k = DEPTH - 2; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    if (adv[0]) begin
      vld_nxt[0] = up_valid;
    end
    for (int k = 1; k < DEPTH; k++) begin
      if (adv[k]) begin
        vld_nxt[k] = vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign up_ready = adv[0];
  assign dn_valid = vld_r[DEPTH-1];

  // carried along unchanged until the output stage
  typedef struct packed {
    logic signed [16:0] era400;
    ecv_tod_t           tod;
    logic               oor;
  } carry_t;

  carry_t c1_r, c2_r, c3_r, c4_r, carry_in;

  assign carry_in.era400 = up_data.era400;
  assign carry_in.tod    = up_data.tod;
  assign carry_in.oor    = up_data.oor;

  // stage 1: year of era
  logic [36:0] py;
  logic [8:0]  yoe1_r;
  logic [17:0] doe1_r;

  assign py = 37'(up_data.t) * 37'(M_365);

  // stage 2: days in whole years, century count
  logic [8:0]  yoe2_r;
  logic [17:0] p365_2_r, p365_nxt;
  logic [1:0]  c100_2_r, c100_nxt;
  logic [17:0] doe2_r;

  assign p365_nxt = 18'(yoe1_r) * 18'd365;
  assign c100_nxt = 2'(yoe1_r >= 9'd100) + 2'(yoe1_r >= 9'd200) + 2'(yoe1_r >= 9'd300);

  // stage 3: day of year, march based
  logic [17:0] ybase;
  logic [8:0]  doy3_r;
  logic [8:0]  yoe3_r;

  assign ybase = p365_2_r + 18'(yoe2_r >> 2) - 18'(c100_2_r);

  // stage 4: march-based month by table search
  logic [3:0] mp4_r, mp_nxt;
  logic [8:0] doy4_r;
  logic [8:0] yoe4_r;

  always_comb begin
    mp_nxt = '0;
    for (int k = 1; k < 12; k++) begin
      if (doy3_r >= month_start(4'(k))) begin
        mp_nxt = mp_nxt + 4'd1;
      end
    end
  end

  // stage 5: calendar fields, zeroed when out of range
  logic [3:0]         month_calc;
  logic [8:0]         day_calc;
  logic signed [16:0] year_calc;
  ecv_result_t        res_r, res_nxt;

  assign month_calc = (mp4_r < 4'd10) ? mp4_r + 4'd3 : mp4_r - 4'd9;
  assign day_calc   = doy4_r - month_start(mp4_r) + 9'd1;
  assign year_calc  = c4_r.era400 + $signed({8'b0, yoe4_r})
                    + $signed({16'b0, (month_calc <= 4'd2)});

  always_comb begin
    if (c4_r.oor) begin
      res_nxt     = '0;
      res_nxt.oor = 1'b1;
    end else begin
      res_nxt.year  = year_calc;
      res_nxt.month = month_calc;
      res_nxt.day   = day_calc[4:0];
      res_nxt.tod   = c4_r.tod;
      res_nxt.oor   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      yoe1_r <= py[35:27];
      doe1_r <= up_data.doe;
      c1_r   <= carry_in;
    end
    if (adv[1]) begin
      yoe2_r   <= yoe1_r;
      p365_2_r <= p365_nxt;
      c100_2_r <= c100_nxt;
      doe2_r   <= doe1_r;
      c2_r     <= c1_r;
    end
    if (adv[2]) begin
      doy3_r <= 9'(doe2_r - ybase);
      yoe3_r <= yoe2_r;
      c3_r   <= c2_r;
    end
    if (adv[3]) begin
      mp4_r  <= mp_nxt;
      doy4_r <= doy3_r;
      yoe4_r <= yoe3_r;
      c4_r   <= c3_r;
    end
    if (adv[4]) begin
      res_r <= res_nxt;
    end
  end

  assign dn_data = res_r;

endmodule

`default_nettype wire

>>> sv/epoch_seconds_to_civil.sv
// top level of the epoch seconds to proleptic gregorian date and time converter
// depends on ecv_pkg, ecv_split, ecv_era, ecv_date and assert_macros.svh
`default_nettype none

// Converts a signed count of seconds since 1970-01-01 00:00:00 into an
// astronomical year, month, day, hour, minute and second. The count is
// floor-divided into whole days and a second of the day, so instants before
// the epoch land on earlier days with a non-negative time (-1 gives
// 1969-12-31 23:59:59). Days map to dates through 400-year eras with a
// march-based year. Both channels are valid/ready; a transfer happens when
// valid and ready are high at a rising clock edge. The block is a fourteen
// stage pipeline (five stages split the day, four find the era, day of era
// and time of day, five build the date, the last being the output register):
// it takes one transfer every cycle unless an output stall has backed up to the
// input. A stalled output holds only the stages behind it that are full; empty
// stages keep filling, so input stays ready while the pipe has a bubble. Inputs
// outside the signed SECONDS_BITS-bit range give out_of_range high and all
// other fields zero. No state is kept besides the pipeline; every input gives
// exactly one result.
module epoch_seconds_to_civil
  import ecv_pkg::*;
#(
  parameter int SECONDS_BITS = 41
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [SECS_W-1:0] in_epoch_seconds,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [16:0]       out_year,
  output logic [3:0]               out_month,
  output logic [4:0]               out_day,
  output logic [4:0]               out_hour,
  output logic [5:0]               out_minute,
  output logic [5:0]               out_second,
  output logic                     out_out_of_range
);

  `include "assert_macros.svh"

  // split to era handoff
  logic      sp_valid, sp_ready;
  ecv_days_t sp_data;

  // era to date handoff
  logic      er_valid, er_ready;
  ecv_era_t  er_data;

  ecv_result_t res;

  // seconds to biased day number and second of day
  ecv_split #(
    .SECONDS_BITS(SECONDS_BITS)
  ) u_split (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .up_secs  (in_epoch_seconds),
    .dn_valid (sp_valid),
    .dn_ready (sp_ready),
    .dn_data  (sp_data)
  );

  // era, day of era and time of day
  ecv_era u_era (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (sp_valid),
    .up_ready (sp_ready),
    .up_data  (sp_data),
    .dn_valid (er_valid),
    .dn_ready (er_ready),
    .dn_data  (er_data)
  );

  // year, month and day, with the output register
  ecv_date u_date (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (er_valid),
    .up_ready (er_ready),
    .up_data  (er_data),
    .dn_valid (out_valid),
    .dn_ready (out_ready),
    .dn_data  (res)
  );

  assign out_year         = res.year;
  assign out_month        = res.month;
  assign out_day          = res.day;
  assign out_hour         = res.tod.hour;
  assign out_minute       = res.tod.minute;
  assign out_second       = res.tod.second;
  assign out_out_of_range = res.oor;

  // an empty output stage means every stage can advance, so input is open
  `ASSERT_ALWAYS(a_ready_when_drained, clk, rst_n, !out_valid |-> in_ready)

  // a valid in-range result is a legal date and time
  `ASSERT_ALWAYS(a_fields_legal, clk, rst_n, (out_valid && !out_out_of_range) |-> (out_month >= 4'd1 && out_month <= 4'd12 && out_day >= 5'd1 && out_day <= 5'd31 && out_hour <= 5'd23 && out_minute <= 6'd59 && out_second <= 6'd59))

  // out of range results carry zero fields
  `ASSERT_ALWAYS(a_oor_zero, clk, rst_n, (out_valid && out_out_of_range) |-> (out_year == 17'sd0 && out_month == 4'd0 && out_day == 5'd0 && out_hour == 5'd0 && out_minute == 6'd0 && out_second == 6'd0))

  // the range flag can only rise when the supported range is narrower than the port
  `ASSERT_ALWAYS(a_oor_needs_narrow, clk, rst_n, out_valid |-> (SECONDS_BITS < SECS_W || !out_out_of_range))

endmodule

`default_nettype wire

>>> tb/sv/epoch_seconds_to_civil_tb.sv
// self-checking testbench for the epoch seconds to civil date converter
// depends on ecv_pkg and epoch_seconds_to_civil; predicts every date and checks it in order
`timescale 1ns / 100ps

module epoch_seconds_to_civil_tb;
  import ecv_pkg::*;

  localparam int SECONDS_BITS = 41;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 40;     // pipeline is fourteen deep, leave plenty of slack
  localparam int TAIL_ITEMS   = 150;    // no idling once this few items remain
  localparam int LONG_HOLD    = 64;     // long enough to back up the whole pipe
  localparam int HOLD_SPACING = 600;
  localparam int RANDOM_ITEMS = 1530;

  localparam longint SECS_PER_DAY = 86400;
  localparam longint EPOCH_SHIFT  = 719468;
  localparam longint ERA_DAYS     = 146097;

  // one entry of the send queue: a timestamp or a marker to wait for an empty pipe
  typedef struct packed {
    logic                     drain;
    logic signed [SECS_W-1:0] secs;
  } epoch_item_t;

  // expected date and time of one transfer, with the timestamp it came from
  typedef struct packed {
    logic signed [SECS_W-1:0] secs;
    logic signed [16:0]       year;
    logic [3:0]               month;
    logic [4:0]               day;
    logic [4:0]               hour;
    logic [5:0]               minute;
    logic [5:0]               second;
    logic                     oor;
  } civil_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic signed [SECS_W-1:0] in_epoch_seconds = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [16:0]       out_year;
  logic [3:0]               out_month;
  logic [4:0]               out_day;
  logic [4:0]               out_hour;
  logic [5:0]               out_minute;
  logic [5:0]               out_second;
  logic                     out_out_of_range;

  epoch_item_t pending[$];
  civil_t      expected_dates[$];

  logic in_took = 1'b0;   // an input transfer happened at the last rising edge
  int   mismatches = 0;
  int   results_seen = 0;
  int   cycle_count = 0;

  // sender side idling
  int send_gap = 0;
  int send_idle_pct = 12;

  // receiver side idling and the long hold-off
  int recv_gap = 0;
  int recv_idle_pct = 12;
  int hold_left = 0;
  int next_hold_at = 300;

  always #2 clk = ~clk;

  epoch_seconds_to_civil #(
    .SECONDS_BITS(SECONDS_BITS)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_epoch_seconds (in_epoch_seconds),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_year         (out_year),
    .out_month        (out_month),
    .out_day          (out_day),
    .out_hour         (out_hour),
    .out_minute       (out_minute),
    .out_second       (out_second),
    .out_out_of_range (out_out_of_range)
  );

  // date and time of day for one timestamp, floor division throughout
  function automatic civil_t civil_from_epoch(input logic signed [SECS_W-1:0] secs);
    longint v;
    longint lim;
    longint days;
    longint sod;
    longint era;
    longint doe;
    longint yoe;
    longint doy;
    longint mp;
    longint m;
    civil_t r;
    v = longint'(secs);
    r = '0;
    r.secs = secs;
    if (SECONDS_BITS < SECS_W) begin
      lim = 64'sd1 <<< (SECONDS_BITS - 1);
      if (v < -lim || v > lim - 1) begin
        // out of range: every date and time field reads zero
        r.oor = 1'b1;
        return r;
      end
    end
    days = v / SECS_PER_DAY;
    sod  = v % SECS_PER_DAY;
    if (sod < 0) begin
      sod  += SECS_PER_DAY;
      days -= 1;
    end
    // shift so day zero is 0000-03-01, then split into 400-year eras
    days += EPOCH_SHIFT;
    era = days / ERA_DAYS;
    doe = days % ERA_DAYS;
    if (doe < 0) begin
      doe += ERA_DAYS;
      era -= 1;
    end
    yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp  = (5 * doy + 2) / 153;
    m   = (mp < 10) ? mp + 3 : mp - 9;
    r.day    = 5'(doy - (153 * mp + 2) / 5 + 1);
    r.month  = 4'(m);
    r.year   = 17'(yoe + era * 400 + ((m <= 2) ? 1 : 0));
    r.hour   = 5'(sod / 3600);
    r.minute = 6'((sod % 3600) / 60);
    r.second = 6'(sod % 60);
    return r;
  endfunction

  function automatic void queue_epoch(input longint v);
    pending.push_back('{drain: 1'b0, secs: v[SECS_W-1:0]});
  endfunction

  function automatic void queue_drain();
    pending.push_back('{drain: 1'b1, secs: '0});
  endfunction

  function automatic int pick_idle_pct();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 12;
      default: return 40;
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input longint secs, input longint got,
                             input longint want);
    if (got != want) begin
      report_mismatch($sformatf("epoch %0d: %s is %0d, expected %0d", secs, name, got, want));
    end
  endtask

  // driver: a new item goes out at the falling edge once the previous one made its transfer
  always @(negedge clk) begin : drive_in
    epoch_item_t item;
    if (rst_n && (!in_valid || in_took)) begin
      if (send_gap != 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending.size() == 0) begin
        in_valid <= 1'b0;
      end else if (pending[0].drain) begin
        // sender pause: hold back until every result is back
        in_valid <= 1'b0;
        if (expected_dates.size() == 0) begin
          item = pending.pop_front();
        end
      end else begin
        item = pending.pop_front();
        in_valid <= 1'b1;
        in_epoch_seconds <= item.secs;
        // idling comes in stretches with different densities, none near the end
        if ($urandom_range(0, 63) == 0) begin
          send_idle_pct = pick_idle_pct();
        end
        if (pending.size() > TAIL_ITEMS && $urandom_range(0, 99) < send_idle_pct) begin
          send_gap = $urandom_range(1, 6);
        end
      end
    end
  end

  // receiver: random stall bursts plus an occasional long hold-off that backs up the pipe
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (results_seen >= next_hold_at && pending.size() > TAIL_ITEMS) begin
      hold_left = LONG_HOLD - 1;
      next_hold_at += HOLD_SPACING;
      out_ready <= 1'b0;
    end else if (recv_gap != 0) begin
      recv_gap--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 63) == 0) begin
        recv_idle_pct = pick_idle_pct();
      end
      if (pending.size() > TAIL_ITEMS && $urandom_range(0, 99) < recv_idle_pct) begin
        recv_gap = $urandom_range(1, 6);
      end
    end
  end

  // monitor: predict on each input transfer, check each output transfer against the oldest
  always @(posedge clk) begin : watch
    civil_t want;
    in_took <= rst_n && in_valid && in_ready;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (expected_dates.size() == 0) begin
        report_mismatch($sformatf("result %0d-%0d-%0d with no transfer waiting",
                                  $signed(out_year), out_month, out_day));
      end else begin
        want = expected_dates.pop_front();
        check_field("year", want.secs, $signed(out_year), $signed(want.year));
        check_field("month", want.secs, out_month, want.month);
        check_field("day", want.secs, out_day, want.day);
        check_field("hour", want.secs, out_hour, want.hour);
        check_field("minute", want.secs, out_minute, want.minute);
        check_field("second", want.secs, out_second, want.second);
        check_field("out_of_range", want.secs, out_out_of_range, want.oor);
      end
    end
    if (rst_n && in_valid && in_ready) begin
      expected_dates.push_back(civil_from_epoch(in_epoch_seconds));
    end
  end

  // run limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Mismatches found");
    $finish;
  end

  initial begin : stimulus
    longint v;
    longint k;
    int     kind;
    // directed: epoch edges, day edges, field extremes, leap days, era edges
    queue_epoch(0);
    queue_epoch(-1);                        // 1969-12-31 23:59:59, all input bits set
    queue_epoch(1);
    queue_epoch(86399);
    queue_epoch(86400);
    queue_epoch(-86400);
    queue_epoch(-86401);
    queue_epoch((64'sd1 <<< 40) - 1);       // largest input
    queue_epoch(-(64'sd1 <<< 40));          // smallest input
    queue_epoch(64'sd951782400);            // 2000-02-29, leap in a century year
    queue_epoch(64'sd951868799);            // last second of that leap day
    queue_epoch(-64'sd2208988800);          // 1900-01-01, century not leap
    queue_epoch(-64'sd2203891200);          // 1900-03-01
    queue_epoch(-64'sd62162035200);         // 0000-03-01, first day of an era
    queue_epoch(-64'sd62162035201);         // last second of the previous era
    queue_epoch(-64'sd62167219200);         // 0000-01-01, year zero
    queue_epoch(-64'sd62167219201);         // into negative years
    queue_epoch(64'sd253402300799);         // 9999-12-31 23:59:59
    queue_epoch(64'sd2147483647);
    queue_epoch(-64'sd2147483648);
    queue_epoch(64'sh0AAAAAAAAAA);          // alternating bit patterns
    queue_epoch(64'sh15555555555);
    queue_drain();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 700 || i == 1200) begin
        queue_drain();
      end
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1, 2: begin
          // anywhere in the 41-bit range
          v = {$urandom, $urandom};
        end
        3, 4: begin
          // a few years around the epoch
          v = longint'($urandom_range(0, 86400 * 1600)) - 64'sd86400 * 800;
        end
        5, 6: begin
          // around an era boundary, on a day edge or anywhere in the day
          k = longint'($urandom_range(0, 174)) - 87;
          v = (k * ERA_DAYS - EPOCH_SHIFT + longint'($urandom_range(0, 400)) - 200)
              * SECS_PER_DAY;
          if ($urandom_range(0, 1) != 0) begin
            v += longint'($urandom_range(0, 86399));
          end else if ($urandom_range(0, 1) != 0) begin
            v += SECS_PER_DAY - 1;
          end
        end
        7: begin
          // near either end of the range
          if ($urandom_range(0, 1) != 0) begin
            v = (64'sd1 <<< 40) - 1 - longint'($urandom_range(0, 86400 * 3));
          end else begin
            v = -(64'sd1 <<< 40) + longint'($urandom_range(0, 86400 * 3));
          end
        end
        default: begin
          // signed 32-bit span, about 68 years either side
          v = longint'($signed($urandom));
        end
      endcase
      queue_epoch(v);
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending.size() != 0 || in_valid || expected_dates.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
